[design/nsf_pkg.sv]
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants and controller/datapath handshake types for the
// normalized spectral flux block.
// ----------------------------------------------------------------------------
`default_nettype none

package nsf_pkg;

  // defaults for the top-level parameters
  localparam int NSF_MAX_BINS   = 1024;
  localparam int NSF_POWER_BITS = 24;

  // fixed field widths
  localparam int FRAME_W   = 11;  // frame_bins register
  localparam int FLUX_W    = 48;  // unsigned Q32.16 result
  localparam int FRAC_BITS = 16;

  localparam logic [FRAME_W-1:0] FRAME_BINS_RESET = 11'd1024;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // capture the input beat, RAM read issued at pos
    logic diff_en;   // register |power - previous bin|
    logic mul_en;    // run the shared squarer
    logic mul_peak;  // squarer operand: previous peak instead of difference
    logic acc_en;    // accumulate, write back bin, advance position
    logic roll;      // frame end: running peak to previous peak, clear divider
    logic div_step;  // one restoring-division step
    logic out_load;  // load result register
  } nsf_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;      // current bin closes the frame
    logic div_last;  // this is the final division step
    logic out_free;  // result register can take a new value
  } nsf_stat_t;

endpackage

`default_nettype wire

[design/nsf_ram.sv]
// ----------------------------------------------------------------------------
// nsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/nsf_ctrl.sv]
// ----------------------------------------------------------------------------
// nsf_ctrl
// Sequencer: per-bin read/difference/square/accumulate, then at frame end
// the peak square, the bit-serial division and the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_ctrl import nsf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire nsf_stat_t stat,
  output nsf_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SQ,
    S_ACC,
    S_ROLL,
    S_DIV,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_SQ;
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = stat.last ? S_ROLL : S_IDLE;
      end
      S_ROLL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_peak = 1'b1;
        cmd.roll     = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/nsf_datapath.sv]
// ----------------------------------------------------------------------------
// nsf_datapath
// Bin store, difference, shared squarer, saturating accumulator, peak
// tracking, restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsf_datapath import nsf_pkg::*; #(
  parameter int MAX_BINS   = NSF_MAX_BINS,
  parameter int POWER_BITS = NSF_POWER_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire nsf_cmd_t              cmd,
  output nsf_stat_t                  stat,
  input  wire logic [POWER_BITS-1:0] power,
  input  wire logic                  frame_bins_we,
  input  wire logic [FRAME_W-1:0]    frame_bins,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [FLUX_W-1:0]     flux
);

  localparam int PB     = POWER_BITS;
  localparam int POS_W  = $clog2(MAX_BINS);
  localparam int CNT_W  = POS_W + 1;
  localparam int PROD_W = 2 * PB;
  localparam int SUM_W  = (PROD_W + POS_W > 64) ? 64 : PROD_W + POS_W;
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DVD_W);

  logic [FRAME_W-1:0] frame_bins_q;
  logic [CNT_W-1:0]   eff_len;
  logic [POS_W-1:0]   pos;
  logic [CNT_W-1:0]   filled;
  logic [PB-1:0]      power_q;
  logic [PB-1:0]      rdata;
  logic [PB-1:0]      old_bin;
  logic [PB-1:0]      diff;
  logic [PB-1:0]      mul_a;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_next;
  logic [PB-1:0]      run_peak;
  logic [PB-1:0]      run_peak_next;
  logic [PB-1:0]      prev_peak;
  logic               peak_zero;
  logic [DVD_W-1:0]   dvd;
  logic [PROD_W-1:0]  rem;
  logic [PROD_W:0]    rem_shift;
  logic [PROD_W:0]    rem_sub;
  logic               q_bit;
  logic [FLUX_W-1:0]  quo;
  logic               ovf;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   pos_inc;

  // frame length clamped to 1..MAX_BINS
  always_comb begin
    if (frame_bins_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (frame_bins_q > MAX_BINS) begin
      eff_len = CNT_W'(MAX_BINS);
    end else begin
      eff_len = CNT_W'(frame_bins_q);
    end
  end

  assign pos_inc = {1'b0, pos} + CNT_W'(1);

  assign stat.last     = pos_inc >= eff_len;
  assign stat.div_last = step == STEP_W'(DVD_W - 1);
  assign stat.out_free = !out_valid || !out_stall;

  nsf_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_BINS),
    .AW    (POS_W)
  ) u_bins (
    .clk   (clk),
    .we    (cmd.acc_en),
    .waddr (pos),
    .wdata (power_q),
    .raddr (pos),
    .rdata (rdata)
  );

  // bins are written as a prefix 0..filled-1; anything past it reads as zero
  assign old_bin = ({1'b0, pos} < filled) ? rdata : '0;

  assign mul_a = cmd.mul_peak ? prev_peak : diff;

  assign sum_add  = {1'b0, sum} + (SUM_W + 1)'(prod);
  assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  assign run_peak_next = (power_q > run_peak) ? power_q : run_peak;

  assign rem_shift = {rem, dvd[DVD_W-1]};
  assign rem_sub   = rem_shift - {1'b0, prod};
  assign q_bit     = rem_shift >= {1'b0, prod};

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bins_q <= FRAME_BINS_RESET;
      pos          <= '0;
      filled       <= '0;
      sum          <= '0;
      run_peak     <= '0;
      prev_peak    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (frame_bins_we) begin
        frame_bins_q <= frame_bins;
      end
      if (cmd.acc_en) begin
        if ({1'b0, pos} == filled) begin
          filled <= pos_inc;
        end
        run_peak <= run_peak_next;
        if (stat.last) begin
          pos <= '0;
          sum <= '0;
        end else begin
          pos <= pos_inc[POS_W-1:0];
          sum <= sum_next;
        end
      end
      if (cmd.roll) begin
        prev_peak <= run_peak;
        run_peak  <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      power_q <= power;
    end
    if (cmd.diff_en) begin
      diff <= (power_q >= old_bin) ? power_q - old_bin : old_bin - power_q;
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_a);
    end
    if (cmd.acc_en && stat.last) begin
      dvd <= {sum_next, FRAC_BITS'(0)};
    end else if (cmd.div_step) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
    end
    if (cmd.roll) begin
      peak_zero <= prev_peak == '0;
      rem       <= '0;
      quo       <= '0;
      ovf       <= 1'b0;
      step      <= '0;
    end else if (cmd.div_step) begin
      rem  <= q_bit ? rem_sub[PROD_W-1:0] : rem_shift[PROD_W-1:0];
      quo  <= {quo[FLUX_W-2:0], q_bit};
      ovf  <= ovf | quo[FLUX_W-1];
      step <= step + STEP_W'(1);
    end
    if (cmd.out_load) begin
      if (peak_zero) begin
        flux <= '0;
      end else if (ovf) begin
        flux <= '1;
      end else begin
        flux <= quo;
      end
    end
  end

endmodule

`default_nettype wire

[design/normalized_spectral_flux.sv]
// Bins: each accepted bin passes RAM read, difference, square and accumulate
//   before the next bin is accepted.
// Frame end: the closing bin is followed by the peak square, the restoring
//   division and the result load; the load, and so the next accept, waits
//   while the sink still holds the previous flux beat.
// Reset (rst, synchronous): frame_bins = 1024, peaks/sum/position cleared.
// ----------------------------------------------------------------------------
// normalized_spectral_flux
// Normalized spectral flux: sum of squared bin differences against the
// previous frame, divided by the previous frame peak squared, Q32.16 out.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_spectral_flux import nsf_pkg::*; #(
  parameter int MAX_BINS   = NSF_MAX_BINS,
  parameter int POWER_BITS = NSF_POWER_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // bin input beats
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [POWER_BITS-1:0] power,
  // flux result beats
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [FLUX_W-1:0]     flux,
  // frame length register
  input  wire logic                  frame_bins_we,
  input  wire logic [FRAME_W-1:0]    frame_bins
);

  // The controller walks each bin through read / diff / square / accumulate.
  // On the closing bin it squares the previous peak on the same multiplier,
  // then runs a restoring divider over sum * 2^16, one quotient bit per cycle.
  // Quotient bits above bit 47 set a sticky overflow that saturates flux.
  // A zero previous peak forces flux to zero.
  // The bin store reads as zero past a fill count, so reset needs no
  // clearing pass.
  // The result register decouples the output: new bins are taken while a
  // finished flux beat still waits for the sink.

  nsf_cmd_t  cmd;
  nsf_stat_t stat;

  nsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsf_datapath #(
    .MAX_BINS   (MAX_BINS),
    .POWER_BITS (POWER_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .power         (power),
    .frame_bins_we (frame_bins_we),
    .frame_bins    (frame_bins),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .flux          (flux)
  );

endmodule

`default_nettype wire
